### rtl/bitmap_page_allocator_macros.svh
// Assertion macros used by the allocator controller.
`ifndef BITMAP_PAGE_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_MACROS_SVH

// Check a property on every clock edge outside reset.
`define BPA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define BPA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/bpa_pkg.sv
// Types and constants shared by the page allocator modules.
package bpa_pkg;

   typedef enum logic [1:0] {
      OP_ALLOC     = 2'd0,
      OP_FREE      = 2'd1,
      OP_MARK_USED = 2'd2,
      OP_MARK_FREE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK          = 2'd0,
      STAT_INVALID_ARG = 2'd1,
      STAT_INVALID_ADR = 2'd2,
      STAT_NO_MEMORY   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_CHECK,
      S_VERIFY,
      S_SCAN_RD,
      S_SCAN_EV,
      S_MARK_RD,
      S_MARK_WR,
      S_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic check;
      logic verify;
      logic scan_rd;
      logic scan_ev;
      logic mark_rd;
      logic mark_wr;
      logic set_nomem;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic   clear_done;
      op_type op;
      logic   final_ok;
      logic   scan_done;
      logic   hit;
      logic   mark_done;
   } sts_type;

   // Width of a word index taken from a 32-bit byte address.
   localparam int WIW = 27;

endpackage

### rtl/bpa_ctrl.sv
// Controller state machine of the page allocator.
`include "bitmap_page_allocator_macros.svh"

module bpa_ctrl
   import bpa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            if (sts.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = S_VERIFY;
         end
         S_VERIFY: begin
            cmd.verify = 1'b1;
            if (!sts.final_ok) state_in = S_DONE;
            else if (sts.op == OP_ALLOC) state_in = S_SCAN_RD;
            else state_in = S_MARK_RD;
         end
         S_SCAN_RD: begin
            if (sts.scan_done) begin
               cmd.set_nomem = 1'b1;
               state_in      = S_DONE;
            end else begin
               cmd.scan_rd = 1'b1;
               state_in    = S_SCAN_EV;
            end
         end
         S_SCAN_EV: begin
            cmd.scan_ev = 1'b1;
            state_in    = sts.hit ? S_MARK_RD : S_SCAN_RD;
         end
         S_MARK_RD: begin
            if (sts.mark_done) begin
               state_in = S_DONE;
            end else begin
               cmd.mark_rd = 1'b1;
               state_in    = S_MARK_WR;
            end
         end
         S_MARK_WR: begin
            cmd.mark_wr = 1'b1;
            state_in    = S_MARK_RD;
         end
         S_DONE: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   `BPA_ASSERT(a_accept_after_clear, (req_tvalid && req_tready) |-> sts.clear_done, "item taken during clear")
   `BPA_ASSERT(a_one_at_a_time, rsp_tvalid |-> !req_tready, "item taken with result pending")
   `BPA_ASSERT(a_rsp_taken_idle, (rsp_tvalid && rsp_tready) |=> (!rsp_tvalid && req_tready), "no return to idle")
   `BPA_ASSERT_ALWAYS(a_reset_quiet, reset |=> (!rsp_tvalid && !req_tready), "busy right after reset")

endmodule

### rtl/bpa_datapath.sv
// Datapath of the page allocator: bitmap memory, argument checks, scan and mark.
module bpa_datapath
   import bpa_pkg::*;
#(
   parameter int MAP_WORDS  = 2048,
   parameter int PAGE_SHIFT = 12
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata,
   input  logic [1:0]  req_command,
   input  logic [16:0] req_page_count,
   input  logic [31:0] req_address,
   input  logic [31:0] req_range_end,
   input  logic [31:0] req_lower_limit,
   input  logic [31:0] req_upper_limit,
   input  cmd_type     cmd,
   output sts_type     sts,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_block_address
);

   localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int PW = AW + 5;
   localparam logic [34:0] TOTAL = 35'(MAP_WORDS) * 35'd32;
   localparam logic [33:0] PMASK = (34'd1 << PAGE_SHIFT) - 34'd1;

   logic [31:0] mem [MAP_WORDS];

   logic [31:0]      min_lo_ff;
   logic [28:0]      max_up_ff;
   op_type           op_ff;
   logic [16:0]      count_ff;
   logic [31:0]      addr_ff, rend_ff, lo_ff, hi_ff;
   logic [33:0]      first_ff, first_in, cnt_ff, cnt_in;
   status_type       err_ff, err_in;
   logic             empty_ff, empty_in;
   logic [WIW-1:0]   word_ff, hiw_ff;
   logic [PW:0]      run_ff, run_in;
   logic [PW-1:0]    start_ff, start_in;
   logic [PW:0]      cur_ff, endp_ff;
   logic             free_mode_ff;
   logic [31:0]      rd_ff;
   logic [AW:0]      clr_ff;
   status_type       res_status_ff, final_status;
   logic [31:0]      res_base_ff;

   logic             clear_done;
   logic [34:0]      endp_w;
   logic             oob;
   logic             hit;
   logic [PW-1:0]    hstart;
   logic [PW-1:0]    wbase;
   logic [5:0]       t31;
   logic [63:0]      base_w;
   logic [31:0]      mword;
   logic [AW-1:0]    rd_addr, wr_addr;
   logic             we;
   logic [31:0]      wdata;

   // Consecutive set bits of w ending at bit b, counted downward.
   function automatic logic [5:0] ones_below(logic [31:0] w, int b);
      logic [5:0] n;
      n = 6'(b + 1);
      for (int j = 0; j < 32; j++) begin
         if (j <= b && !w[j]) n = 6'(b - j);
      end
      return n;
   endfunction

   assign clear_done = (clr_ff == (AW+1)'(MAP_WORDS));

   // Config registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_lo_ff <= 32'h0010_0000;
         max_up_ff <= 29'h1000_0000;
      end else if (csr_we) begin
         if (csr_index) max_up_ff <= csr_wdata[28:0];
         else min_lo_ff <= csr_wdata;
      end
   end

   // Argument checks and page range of the command.
   always_comb begin
      logic [33:0] addr_pg, up, diff;
      addr_pg  = 34'(addr_ff >> PAGE_SHIFT);
      up       = ({2'b0, rend_ff} + PMASK) >> PAGE_SHIFT;
      diff     = (({2'b0, rend_ff} - {2'b0, addr_ff}) + PMASK) >> PAGE_SHIFT;
      first_in = addr_pg;
      cnt_in   = 34'(count_ff);
      err_in   = STAT_OK;
      empty_in = 1'b0;
      unique case (op_ff)
         OP_ALLOC: begin
            if (count_ff == 17'd0 || lo_ff < min_lo_ff || hi_ff > {3'b0, max_up_ff} ||
                35'(hi_ff >> PAGE_SHIFT) > TOTAL)
               err_in = STAT_INVALID_ARG;
            else if ((34'(lo_ff) & PMASK) != 34'd0 || (34'(hi_ff) & PMASK) != 34'd0)
               err_in = STAT_INVALID_ADR;
         end
         OP_FREE: begin
            if (addr_ff == 32'd0 || (34'(addr_ff) & PMASK) != 34'd0)
               err_in = STAT_INVALID_ADR;
         end
         OP_MARK_USED: begin
            empty_in = (up <= addr_pg);
            cnt_in   = up - addr_pg;
         end
         OP_MARK_FREE: begin
            empty_in = (rend_ff <= addr_ff);
            cnt_in   = diff;
         end
         default: err_in = STAT_OK;
      endcase
   end

   assign endp_w = 35'(first_ff) + 35'(cnt_ff);
   assign oob    = endp_w > TOTAL;

   always_comb begin
      if (err_ff != STAT_OK) final_status = err_ff;
      else if (op_ff != OP_ALLOC && !empty_ff && oob) final_status = STAT_INVALID_ARG;
      else final_status = STAT_OK;
   end

   // First-fit evaluation of one bitmap word.
   assign wbase = {word_ff[AW-1:0], 5'b0};
   assign t31   = ones_below(rd_ff, 31);

   always_comb begin
      logic [5:0]    t;
      logic          allb;
      logic [PW+1:0] len;
      hit    = 1'b0;
      hstart = '0;
      for (int b = 31; b >= 0; b--) begin
         t    = ones_below(rd_ff, b);
         allb = (t == 6'(b + 1));
         len  = allb ? ((PW+2)'(run_ff) + (PW+2)'(b + 1)) : (PW+2)'(t);
         if (rd_ff[b] && 64'(len) >= 64'(count_ff)) begin
            hit    = 1'b1;
            hstart = (allb && run_ff != '0) ? start_ff
                                            : wbase + PW'(b + 1) - PW'(t);
         end
      end
   end

   always_comb begin
      if (rd_ff == 32'hffff_ffff) begin
         run_in   = run_ff + (PW+1)'(32);
         start_in = (run_ff != '0) ? start_ff : wbase;
      end else begin
         run_in   = (PW+1)'(t31);
         start_in = wbase + PW'(32) - PW'(t31);
      end
   end

   assign base_w = 64'(hstart) << PAGE_SHIFT;

   // Bits of the current word that fall in [cur, end).
   always_comb begin
      logic [5:0] lo_b, hi_b;
      lo_b = {1'b0, cur_ff[4:0]};
      hi_b = (endp_ff[PW:5] == cur_ff[PW:5]) ? {1'b0, endp_ff[4:0]} : 6'd32;
      for (int j = 0; j < 32; j++) begin
         if (6'(j) >= lo_b && 6'(j) < hi_b) mword[j] = free_mode_ff | rd_ff[j];
         else mword[j] = rd_ff[j];
         if (!free_mode_ff && 6'(j) >= lo_b && 6'(j) < hi_b) mword[j] = 1'b0;
      end
   end

   assign rd_addr = cmd.scan_rd ? word_ff[AW-1:0] : cur_ff[PW-1:5];
   assign we      = !clear_done || cmd.mark_wr;
   assign wr_addr = clear_done ? cur_ff[PW-1:5] : clr_ff[AW-1:0];
   assign wdata   = clear_done ? mword : 32'd0;

   always_ff @(posedge clock) begin
      if (we) mem[wr_addr] <= wdata;
      rd_ff <= mem[rd_addr];
   end

   // Clearing pass after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (!clear_done) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= op_type'(req_command);
         count_ff <= req_page_count;
         addr_ff  <= req_address;
         rend_ff  <= req_range_end;
         lo_ff    <= req_lower_limit;
         hi_ff    <= req_upper_limit;
      end
      if (cmd.check) begin
         first_ff <= first_in;
         cnt_ff   <= cnt_in;
         err_ff   <= err_in;
         empty_ff <= empty_in;
      end
      if (cmd.verify) begin
         res_status_ff <= final_status;
         res_base_ff   <= 32'd0;
         word_ff       <= WIW'(lo_ff >> (PAGE_SHIFT + 5));
         hiw_ff        <= WIW'(hi_ff >> (PAGE_SHIFT + 5));
         run_ff        <= '0;
         cur_ff        <= first_ff[PW:0];
         endp_ff       <= empty_ff ? first_ff[PW:0] : endp_w[PW:0];
         free_mode_ff  <= (op_ff != OP_MARK_USED);
      end
      if (cmd.set_nomem) res_status_ff <= STAT_NO_MEMORY;
      if (cmd.scan_ev) begin
         if (hit) begin
            cur_ff       <= {1'b0, hstart};
            endp_ff      <= {1'b0, hstart} + (PW+1)'(count_ff);
            free_mode_ff <= 1'b0;
            res_base_ff  <= base_w[31:0];
         end else begin
            word_ff  <= word_ff + 1'b1;
            run_ff   <= run_in;
            start_ff <= start_in;
         end
      end
      if (cmd.mark_wr) cur_ff <= {cur_ff[PW:5] + 1'b1, 5'b0};
   end

   assign sts.clear_done = clear_done;
   assign sts.op         = op_ff;
   assign sts.final_ok   = (final_status == STAT_OK);
   assign sts.scan_done  = (word_ff >= hiw_ff);
   assign sts.hit        = hit;
   assign sts.mark_done  = (cur_ff >= endp_ff);

   assign rsp_status        = res_status_ff;
   assign rsp_block_address = res_base_ff;

endmodule

### rtl/bitmap_page_allocator.sv
// Bitmap page allocator: one command per item, one result item per command.
// After reset the block clears its bitmap memory, one word a cycle, before it takes
// the first item. From its acceptance an item passes the argument checks; an alloc
// then searches the bitmap words first-fit and marks the run it finds as used, and
// free and the range commands mark each word of their range. Each marked word is
// read and then written back in the bitmap memory. An item that fails its argument
// checks goes straight to its result. The result item waits in its register until
// taken, and the next item can be accepted in the cycle after that.
module bitmap_page_allocator
   import bpa_pkg::*;
#(
   parameter int MAP_WORDS  = 2048,
   parameter int PAGE_SHIFT = 12
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [31:0]  csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [151:0] req_tdata,  // page_count, address, range_end, lower_limit, upper_limit
   input  logic [1:0]   req_tuser,  // command
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,  // block_address
   output logic [1:0]   rsp_tuser   // status
);

   cmd_type cmd;
   sts_type sts;

   bpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bpa_datapath #(
      .MAP_WORDS  (MAP_WORDS),
      .PAGE_SHIFT (PAGE_SHIFT)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_command       (req_tuser),
      .req_page_count    (req_tdata[16:0]),
      .req_address       (req_tdata[48:17]),
      .req_range_end     (req_tdata[80:49]),
      .req_lower_limit   (req_tdata[112:81]),
      .req_upper_limit   (req_tdata[144:113]),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_status        (rsp_tuser),
      .rsp_block_address (rsp_tdata)
   );

endmodule
